@@ hw/rtl/sstf_pkg.sv @@
package sstf_pkg;

  // Widths of the port fields.
  localparam int unsigned CYL_W   = 13;
  localparam int unsigned TOTAL_W = 23;

  // Default sizing of the request store.
  localparam int unsigned MAX_REQUESTS_DEF  = 1024;
  localparam int unsigned CYLINDER_BITS_DEF = 13;

  // Control from the sequencer to the selection datapath.
  typedef struct packed {
    logic batch_start;  // load the head from the start cylinder, clear the total
    logic scan_clear;   // forget the best candidate before a new scan
    logic cmp_en;       // a stored entry is on the read data this cycle
    logic commit;       // serve the best candidate
  } pick_ctl_t;

endpackage

@@ hw/rtl/sstf_seek_distance.sv @@
// Shortest-seek-time-first scheduler. Requests are written one per word into a single-port-read
// RAM, one cycle each; the word with last set closes the batch. Starting from start_cylinder,
// the block then scans every stored entry once per served request through the RAM read port,
// picks the nearest unserved one (the earliest on a tie), adds its distance to a total that
// saturates at all ones and marks it served in the same RAM word. For a batch of n stored
// requests, scheduling serves all of them in turn, after which one result
// word carries the total and whether any request beyond MAX_REQUESTS was dropped. Input words
// are stalled during scheduling; a finished result may wait on the output while the next batch
// loads. The served mark is written with each request, so the store needs no clearing pass.
module sstf_seek_distance #(
  parameter int unsigned MAX_REQUESTS  = sstf_pkg::MAX_REQUESTS_DEF,
  parameter int unsigned CYLINDER_BITS = sstf_pkg::CYLINDER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sstf_pkg::CYL_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sstf_pkg::CYL_W-1:0]   cylinder_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sstf_pkg::TOTAL_W-1:0] total_movement_o,
  output logic                         overflow_o
);

  localparam int unsigned IW = $clog2(MAX_REQUESTS);
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned RW = CYLINDER_BITS + 1;

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] remaining_q, remaining_d;
  logic [CW-1:0] issue_q, issue_d;
  logic          drop_q, drop_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic [sstf_pkg::CYL_W-1:0] start_q;

  logic          out_valid_q, out_valid_d;
  logic [sstf_pkg::TOTAL_W-1:0] total_q;
  logic          ovf_q;
  logic          out_load;

  logic          in_acc;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  sstf_pkg::pick_ctl_t      ctl;
  logic [IW-1:0]            best_idx;
  logic [CYLINDER_BITS-1:0] best_cyl;
  logic                     best_valid;
  logic [sstf_pkg::TOTAL_W-1:0] pick_total;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Each RAM word holds the served mark above the cylinder.
  sstf_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_REQUESTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  sstf_pick #(
    .CYLINDER_BITS(CYLINDER_BITS),
    .IDX_W        (IW)
  ) u_pick (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .start_i      (start_q),
    .rd_cyl_i     (ram_rdata[CYLINDER_BITS-1:0]),
    .rd_served_i  (ram_rdata[CYLINDER_BITS]),
    .rd_idx_i     (rd_idx_q),
    .best_idx_o   (best_idx),
    .best_cyl_o   (best_cyl),
    .best_valid_o (best_valid),
    .total_o      (pick_total)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    remaining_d = remaining_q;
    issue_d     = issue_q;
    drop_d      = drop_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    out_load    = 1'b0;
    ctl         = '0;
    ctl.cmp_en  = rd_vld_q;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (count_q < CW'(MAX_REQUESTS)) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[IW-1:0];
            ram_wdata = {1'b0, CYLINDER_BITS'(cylinder_i)};
            count_d   = count_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            ctl.batch_start = 1'b1;
            ctl.scan_clear  = 1'b1;
            issue_d         = '0;
            remaining_d     = count_d;
            state_d         = (count_d == '0) ? S_OUT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue_q != count_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q[IW-1:0];
          issue_d  = issue_q + CW'(1);
        end else begin
          // The last entry is compared at this edge.
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ram_we      = 1'b1;
        ram_waddr   = best_idx;
        ram_wdata   = {1'b1, best_cyl};
        ctl.commit  = 1'b1;
        remaining_d = remaining_q - CW'(1);
        if (remaining_q == CW'(1)) begin
          state_d = S_OUT;
        end else begin
          ctl.scan_clear = 1'b1;
          issue_d        = '0;
          state_d        = S_SCAN;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          count_d  = '0;
          drop_d   = 1'b0;
          state_d  = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      remaining_q <= '0;
      issue_q     <= '0;
      drop_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remaining_q <= remaining_d;
      issue_q     <= issue_d;
      drop_q      <= drop_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    if (out_load) begin
      total_q <= pick_total;
      ovf_q   <= drop_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign total_movement_o = total_q;
  assign overflow_o       = ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_REQUESTS))
    else $error("request count beyond store capacity");

  a_remaining_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> (remaining_q <= count_q))
    else $error("more requests left to serve than are stored");

  a_commit_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> best_valid)
    else $error("serving a request without a selected candidate");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result word raised outside the result state");

endmodule

@@ hw/rtl/sstf_ram.sv @@
module sstf_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sstf_pick.sv @@
module sstf_pick #(
  parameter int unsigned CYLINDER_BITS = sstf_pkg::CYLINDER_BITS_DEF,
  parameter int unsigned IDX_W         = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sstf_pkg::pick_ctl_t         ctl_i,
  input  logic [sstf_pkg::CYL_W-1:0]  start_i,
  input  logic [CYLINDER_BITS-1:0]    rd_cyl_i,
  input  logic                        rd_served_i,
  input  logic [IDX_W-1:0]            rd_idx_i,
  output logic [IDX_W-1:0]            best_idx_o,
  output logic [CYLINDER_BITS-1:0]    best_cyl_o,
  output logic                        best_valid_o,
  output logic [sstf_pkg::TOTAL_W-1:0] total_o
);

  // The head register is wide enough for both the start cylinder and a stored cylinder.
  localparam int unsigned HW =
    (CYLINDER_BITS > sstf_pkg::CYL_W) ? CYLINDER_BITS : sstf_pkg::CYL_W;
  localparam int unsigned TW = sstf_pkg::TOTAL_W;

  logic [HW-1:0]            head_q, head_d;
  logic [TW-1:0]            total_q, total_d;
  logic                     best_valid_q, best_valid_d;
  logic [HW-1:0]            best_dist_q, best_dist_d;
  logic [IDX_W-1:0]         best_idx_q, best_idx_d;
  logic [CYLINDER_BITS-1:0] best_cyl_q, best_cyl_d;

  logic [HW-1:0] cyl_ext;
  logic [HW-1:0] gap;
  logic [TW:0]   sum;

  assign cyl_ext = HW'(rd_cyl_i);
  assign gap     = (head_q >= cyl_ext) ? (head_q - cyl_ext) : (cyl_ext - head_q);
  assign sum     = {1'b0, total_q} + (TW + 1)'(best_dist_q);

  always_comb begin
    head_d       = head_q;
    total_d      = total_q;
    best_valid_d = best_valid_q;
    best_dist_d  = best_dist_q;
    best_idx_d   = best_idx_q;
    best_cyl_d   = best_cyl_q;

    if (ctl_i.batch_start) begin
      head_d  = HW'(start_i);
      total_d = '0;
    end

    if (ctl_i.commit) begin
      // The total saturates at its all-ones value.
      total_d = sum[TW] ? '1 : sum[TW-1:0];
      head_d  = HW'(best_cyl_q);
    end

    if (ctl_i.scan_clear) begin
      best_valid_d = 1'b0;
    end

    // Strictly smaller only, so the earliest of equally near requests stays.
    if (ctl_i.cmp_en && !rd_served_i && (!best_valid_q || (gap < best_dist_q))) begin
      best_valid_d = 1'b1;
      best_dist_d  = gap;
      best_idx_d   = rd_idx_i;
      best_cyl_d   = rd_cyl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      total_q      <= '0;
      best_valid_q <= 1'b0;
    end else begin
      head_q       <= head_d;
      total_q      <= total_d;
      best_valid_q <= best_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_dist_q <= best_dist_d;
    best_idx_q  <= best_idx_d;
    best_cyl_q  <= best_cyl_d;
  end

  assign best_idx_o   = best_idx_q;
  assign best_cyl_o   = best_cyl_q;
  assign best_valid_o = best_valid_q;
  assign total_o      = total_q;

endmodule

@@ test/sstf_seek_distance_test.sv @@
module sstf_seek_distance_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYL_W   = sstf_pkg::CYL_W;
  localparam int unsigned TOTAL_W = sstf_pkg::TOTAL_W;

  localparam int unsigned      STORE_DEPTH = sstf_pkg::MAX_REQUESTS_DEF;
  localparam int unsigned      TOTAL_CAP   = (1 << TOTAL_W) - 1;
  localparam logic [CYL_W-1:0] CYL_MAX     = '1;
  localparam int unsigned      CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               overflow;
  } seek_result_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [CYL_W-1:0]   cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [CYL_W-1:0]   cylinder     = '0;
  logic               last         = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [TOTAL_W-1:0] total_movement;
  logic               overflow;

  // Model of the block: the stored batch and the configured head start.
  logic [CYL_W-1:0]   pending_cyl [STORE_DEPTH];
  int unsigned        pending_count   = 0;
  bit                 pending_dropped = 1'b0;
  logic [CYL_W-1:0]   start_cyl_model = '0;

  seek_result_t       expected_results [$];
  int unsigned        send_idle_pct   = 0;
  int unsigned        recv_idle_pct   = 0;
  int unsigned        items_sent      = 0;
  int unsigned        batches_checked = 0;
  int unsigned        mismatches      = 0;
  int unsigned        cycle_count     = 0;

  sstf_seek_distance u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cylinder_i       (cylinder),
    .last_i           (last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .total_movement_o (total_movement),
    .overflow_o       (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Serve the stored batch nearest-first from the configured start cylinder.
  function automatic logic [TOTAL_W-1:0] compute_total_movement();
    bit          served [STORE_DEPTH];
    int unsigned head;
    int unsigned sum;
    int unsigned best_dist;
    int unsigned best_idx;
    int unsigned gap;
    served = '{default: 1'b0};
    head   = start_cyl_model;
    sum    = 0;
    repeat (pending_count) begin
      best_dist = 32'hFFFF_FFFF;
      best_idx  = 0;
      for (int i = 0; i < pending_count; i++) begin
        if (!served[i]) begin
          gap = (pending_cyl[i] >= head) ? pending_cyl[i] - head : head - pending_cyl[i];
          // Strictly less, so the earliest of equally near requests is kept.
          if (gap < best_dist) begin
            best_dist = gap;
            best_idx  = i;
          end
        end
      end
      sum = sum + best_dist;
      if (sum > TOTAL_CAP) sum = TOTAL_CAP;
      head = pending_cyl[best_idx];
      served[best_idx] = 1'b1;
    end
    return sum[TOTAL_W-1:0];
  endfunction

  always @(posedge clk) begin
    seek_result_t got;
    seek_result_t want;
    if (rst_n && in_valid && !in_stall) begin
      if (pending_count < STORE_DEPTH) begin
        pending_cyl[pending_count] = cylinder;
        pending_count++;
      end else begin
        pending_dropped = 1'b1;
      end
      if (last) begin
        want.total    = compute_total_movement();
        want.overflow = pending_dropped;
        expected_results.push_back(want);
        pending_count   = 0;
        pending_dropped = 1'b0;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      got.total    = total_movement;
      got.overflow = overflow;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual total %0d overflow %0b",
                 $time, got.total, got.overflow);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.total !== want.total) begin
          $display("%0t: total_movement mismatch, expected %0d, actual %0d",
                   $time, want.total, got.total);
          mismatches++;
        end
        if (got.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch, expected %0b, actual %0b",
                   $time, want.overflow, got.overflow);
          mismatches++;
        end
        batches_checked++;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles with %0d results outstanding",
               $time, CYCLE_LIMIT, expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [CYL_W-1:0] cyl, input logic is_last);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      cylinder <= CYL_W'($urandom);
      last     <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cylinder <= cyl;
    last     <= is_last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic set_start_cylinder(input logic [CYL_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    start_cyl_model = value;
    @(negedge clk);
  endtask

  // Let the block go idle before the configuration may change.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CYL_W-1:0] pick_cylinder();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CYL_MAX;
      2, 3:    return CYL_W'($urandom_range(0, 31));
      default: return CYL_W'($urandom_range(0, CYL_MAX));
    endcase
  endfunction

  function automatic logic [CYL_W-1:0] pick_start();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CYL_MAX;
      2:       return CYL_W'($urandom_range(0, 31));
      default: return CYL_W'($urandom_range(0, CYL_MAX));
    endcase
  endfunction

  task automatic test_lone_request();
    set_start_cylinder('0);
    send_word(CYL_MAX, 1'b1);
    drain_results();
    set_start_cylinder(CYL_MAX);
    send_word('0, 1'b1);
    drain_results();
    set_start_cylinder('0);
    send_word('0, 1'b1);
    drain_results();
  endtask

  task automatic test_equal_distance();
    // 90 and 110 are equally near 100; taking 90 first gives a different total.
    set_start_cylinder(13'd100);
    send_word(13'd90, 1'b0);
    send_word(13'd110, 1'b0);
    send_word(13'd50, 1'b1);
    drain_results();
    set_start_cylinder(13'd5);
    send_word(13'd5, 1'b0);
    send_word(13'd5, 1'b0);
    send_word(13'd9, 1'b0);
    send_word(13'd1, 1'b1);
    drain_results();
  endtask

  task automatic test_wide_spread();
    set_start_cylinder(13'd4096);
    send_word('0, 1'b0);
    send_word(CYL_MAX, 1'b0);
    send_word(13'd4096, 1'b0);
    send_word(13'd1, 1'b0);
    send_word(CYL_MAX - 1'b1, 1'b1);
    drain_results();
    set_start_cylinder(CYL_MAX);
    send_word(CYL_MAX, 1'b0);
    send_word('0, 1'b1);
    drain_results();
  endtask

  task automatic test_store_full();
    // Two words past capacity; the closing one is itself dropped.
    set_start_cylinder(pick_start());
    for (int i = 0; i < STORE_DEPTH + 2; i++) begin
      send_word(pick_cylinder(), i == STORE_DEPTH + 1);
    end
    drain_results();
    // The dropped flag must not carry into the next batch.
    send_word(13'd7, 1'b0);
    send_word(13'd3000, 1'b1);
    drain_results();
  endtask

  task automatic test_random_batches(input int unsigned n_items, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned target;
    int unsigned batch_len;
    target        = items_sent + n_items;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_start_cylinder(pick_start());
    while (items_sent < target) begin
      batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < batch_len; i++) begin
        send_word(pick_cylinder(), i == batch_len - 1);
      end
      if ($urandom_range(0, 7) == 0) begin
        drain_results();
        set_start_cylinder(pick_start());
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 34;
    recv_idle_pct = 87;
    test_lone_request();
    test_equal_distance();
    test_wide_spread();
    test_store_full();

    test_random_batches(150, 34, 87);
    set_start_cylinder(CYL_MAX);
    test_random_batches(150, 87, 34);
    set_start_cylinder('0);
    test_random_batches(150, 0, 0);

    recv_idle_pct = 0;
    repeat (16) @(posedge clk);
    $display("Sent %0d request words and checked %0d batch totals, including a batch past",
             items_sent, batches_checked);
    $display("store capacity, equal-distance ties and head starts at both ends.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
